### src/srtr_pkg.sv
`default_nettype none

package srtr_pkg;

    // table geometry
    localparam int DEPTH = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // request and result field widths
    localparam int IDX_W = 4;
    localparam int VAL_W = 32;
    localparam int TDATA_W = ((IDX_W + VAL_W + 7) / 8) * 8;
    localparam int PAD_W = TDATA_W - IDX_W - VAL_W;

    // width wide enough to compare an index against the table depth
    localparam int RANGE_W = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

    // request queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_REPLACE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic                    err;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } srtr_req_t;

endpackage

`default_nettype wire

### src/srtr_front.sv
`default_nettype none

module srtr_front
    import srtr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    in_cmd,
    input  wire logic [IDX_W-1:0]        in_index,
    input  wire logic signed [VAL_W-1:0] in_value,
    output logic                         q_valid,
    input  wire logic                    q_pop,
    output srtr_req_t                    q_req
);

    srtr_req_t          q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    logic               pop;
    srtr_req_t          new_req;

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_req    = q_mem[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = q_pop && q_valid;

    // classify: flag indices past the end of the table
    always_comb
    begin
        new_req.cmd   = in_cmd;
        new_req.index = in_index;
        new_req.value = in_value;
        new_req.err   = (RANGE_W'(in_index) >= RANGE_W'(DEPTH));
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### src/srtr_back.sv
`default_nettype none

module srtr_back
    import srtr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    output logic                         q_pop,
    input  wire srtr_req_t               q_req,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [IDX_W-1:0]             out_index,
    output logic signed [VAL_W-1:0]      out_value,
    output logic                         out_status
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_FINAL = 4'b1000
    } back_state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    back_state_t               state_reg, state_next;
    logic                      cmd_reg, cmd_next;
    logic                      up_reg, up_next;
    logic [ADDR_W-1:0]         p_reg, p_next;
    logic signed [VAL_W-1:0]   val_reg, val_next;

    logic signed [VAL_W-1:0]   mem [DEPTH];
    logic [DEPTH-1:0]          entry_valid_reg;
    logic signed [VAL_W-1:0]   rd_data_reg;

    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic signed [VAL_W-1:0]   wr_data;

    logic                      out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]          out_index_reg;
    logic signed [VAL_W-1:0]   out_value_reg;
    logic                      out_status_reg;

    logic                      out_load;
    logic [IDX_W-1:0]          res_index;
    logic signed [VAL_W-1:0]   res_value;
    logic                      res_status;

    logic                      up_now;
    logic [ADDR_W-1:0]         q_addr;
    logic                      swap;
    logic                      more;

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        up_next    = up_reg;
        p_next     = p_reg;
        val_next   = val_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = p_reg;
        wr_en      = 1'b0;
        wr_addr    = p_reg;
        wr_data    = val_reg;
        out_load   = 1'b0;
        res_index  = IDX_W'(p_reg);
        res_value  = '0;
        res_status = STATUS_OK;
        up_now     = (val_reg > rd_data_reg);
        q_addr     = up_reg ? p_reg + 1'b1 : p_reg - 1'b1;
        swap       = up_reg ? (val_reg > rd_data_reg) : (rd_data_reg > val_reg);
        more       = up_reg ? (q_addr != LAST_ADDR) : (q_addr != '0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_req.cmd;
                    p_next   = ADDR_W'(q_req.index);
                    val_next = q_req.value;
                    if (q_req.err)
                    begin
                        out_load   = 1'b1;
                        res_index  = q_req.index;
                        res_status = STATUS_RANGE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(q_req.index);
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                // old entry is in rd_data_reg
                if (cmd_reg == CMD_READ)
                begin
                    out_load   = 1'b1;
                    res_value  = rd_data_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    up_next = up_now;
                    if (up_now && (p_reg != LAST_ADDR))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = p_reg + 1'b1;
                        state_next = ST_CMP;
                    end
                    else if (!up_now && (p_reg != '0))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = p_reg - 1'b1;
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CMP:
            begin
                // neighbour at q_addr is in rd_data_reg
                if (swap)
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg;
                    p_next  = q_addr;
                    if (more)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = up_reg ? q_addr + 1'b1 : q_addr - 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FINAL;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                // moved to an end of the table
                wr_en      = 1'b1;
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    // unwritten entries read as zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            entry_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        up_reg  <= up_next;
        p_reg   <= p_next;
        val_reg <= val_next;
        if (out_load)
        begin
            out_index_reg  <= res_index;
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### src/sorted_table_replace_reposition_unit.sv
// an out-of-range request is answered from the back end idle state, a read after the table
// read, a replace after reading the old entry, one compare-and-swap step per neighbour until
// the order holds or an end is reached, and a final write. the back end holds one request at
// a time and takes the next only once the result register has emptied, the table memory
// stepping one neighbour per cycle; the request queue keeps taking requests while it has room.
// reset clears control state and the entry valid bits, so the table reads as all zeros
`default_nettype none

module sorted_table_replace_reposition_unit
    import srtr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [TDATA_W-1:0] s_axis_tdata,   // index, value, zero pad
    input  wire logic               s_axis_tuser,   // cmd
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // final_index, read_value, zero pad
    output logic                    m_axis_tuser    // status
);

    // front to back request queue
    logic                    q_valid;
    logic                    q_pop;
    srtr_req_t               q_req;

    // unpacked request fields
    logic [IDX_W-1:0]        in_index;
    logic signed [VAL_W-1:0] in_value;

    // result fields from the back end output register
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;

    assign in_index = s_axis_tdata[IDX_W-1:0];
    assign in_value = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];

    // front end: accepts requests, flags bad indices, queues them
    srtr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser),
        .in_index (in_index),
        .in_value (in_value),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    // back end: table memory, reposition sequencer and result register
    srtr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_req      (q_req),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_index  (out_index),
        .out_value  (out_value),
        .out_status (m_axis_tuser)
    );

    // pack result: index in the low bits, value above, zero pad on top
    assign m_axis_tdata = {{PAD_W{1'b0}}, out_value, out_index};

endmodule

`default_nettype wire
